@@ design/hqe_pkg.sv @@
`default_nettype none

package hqe_pkg;

   // Sizing of the histogram
   localparam int NUM_BINS    = 40;
   localparam int COUNT_WIDTH = 32;

   localparam int DATA_W    = 16;
   localparam int FRAC_W    = 17;
   localparam int BIN_IDX_W = $clog2(NUM_BINS);
   localparam int BIN_CNT_W = $clog2(NUM_BINS + 1);
   localparam int USED_W    = COUNT_WIDTH + BIN_CNT_W;
   localparam int PROD_W    = COUNT_WIDTH + FRAC_W;
   localparam int TOT_EXT_W = COUNT_WIDTH + 32;

   // Restoring divider
   localparam int DIV_D_W   = $clog2((NUM_BINS + 1) * 65536);
   localparam int DIV_V_W   = 16;
   localparam int DIV_Q_W   = 17;
   localparam int DIV_S_W   = DIV_V_W + DIV_Q_W - 1;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

   // b * span product for the quantile position
   localparam int QP_W = BIN_CNT_W + 18;

   // Quantile position: floor(m / NUM_BINS) as (m * QR_MUL) >> QR_SH,
   // exact for any m below 2**DIV_D_W
   localparam int QR_SH  = DIV_D_W + BIN_IDX_W;
   localparam int QR_W   = DIV_D_W + 2;
   localparam int QR_P_W = DIV_D_W + QR_W;
   localparam logic [QR_W-1:0] QR_MUL =
      QR_W'(((longint'(1) << QR_SH) + longint'(NUM_BINS) - 1) / longint'(NUM_BINS));

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   // Opcodes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_BINNED = 2'd0;
   localparam logic [1:0] ST_BELOW  = 2'd1;
   localparam logic [1:0] ST_ABOVE  = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   // Register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH = 1'b1;

   localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = -16'sd6144;
   localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 16'sd6144;

   typedef struct packed {
      logic [1:0]               opcode;
      logic signed [DATA_W-1:0] sample;
      logic [FRAC_W-1:0]        fraction;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [5:0]               bin_index;
      logic signed [DATA_W-1:0] quantile_value;
      logic [31:0]              sample_total;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       accept;
      logic       inc_total;
      logic       inc_under;
      logic       inc_over;
      logic       clear_all;
      logic       div_bin;
      logic       bin_capture;
      logic       mem_rd;
      logic       rd_next;
      logic       bin_write;
      logic       prod_load;
      logic       walk_step;
      logic       div_query;
      logic       q_capture;
      logic       status_load;
      logic [1:0] status_code;
      logic       rsp_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       below;
      logic       above;
      logic       walk_stop;
      logic       div_done;
   } dp_sts_type;

endpackage

`default_nettype wire

@@ design/histogram_quantile_engine_core.sv @@
// Fixed-bin histogram with quantile query.
// Request channel (req_valid / req_stall / req_data): one transaction per
// operation: add sample, quantile query or clear. Response channel
// (rsp_valid / rsp_stall / rsp_data): exactly one transaction per request,
// in request order. Config channel (csr_valid / csr_ready / csr_index /
// csr_data) sets the range edges; it is always ready and should be written
// only while no request is in flight.
// One request is processed at a time. Clear, unused opcode and
// out-of-range samples go from decode straight to the response state; an
// in-range sample runs the bit-serial divider by the span plus a
// read-modify-write of the bin store; a query steps bins (one bin store
// read per step, then a reciprocal multiply for the position). The next
// request is taken in the idle state after the response is loaded; the
// longest item is a query that steps over all 40 bins.
// The response sits in an output register; a new request is taken while
// it waits. If the receiver stalls, the next result holds in the response
// state and req_stall stays high until the output register frees up.
// Synchronous reset clears all counters (via per-bin valid bits, no sweep),
// restores the default range and empties the response register.
`default_nettype none

module histogram_quantile_engine_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire hqe_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output hqe_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hqe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hqe_pkg::DATA_W-1:0]     csr_data
);

   hqe_pkg::dp_cmd_type cmd;
   hqe_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   hqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hqe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ design/hqe_div.sv @@
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module hqe_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [hqe_pkg::DIV_D_W-1:0]       dividend,
   input  wire logic [hqe_pkg::DIV_V_W-1:0]       divisor,
   output logic                                   done,
   output logic [hqe_pkg::DIV_Q_W-1:0]            quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [hqe_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [hqe_pkg::DIV_D_W-1:0]       rem_ff, rem_in;
   logic [hqe_pkg::DIV_S_W-1:0]       dsh_ff, dsh_in;
   logic [hqe_pkg::DIV_Q_W-1:0]       quo_ff, quo_in;
   logic                              fits;

   // Trial subtract against the shifted divisor
   assign fits = (hqe_pkg::DIV_S_W'(rem_ff) >= dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dsh_in  = {divisor, {(hqe_pkg::DIV_Q_W-1){1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff[hqe_pkg::DIV_D_W-1:0];
         end
         quo_in = {quo_ff[hqe_pkg::DIV_Q_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + hqe_pkg::DIV_CNT_W'(1);
         if (cnt_ff == hqe_pkg::DIV_CNT_W'(hqe_pkg::DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // A new divide is never launched over a running one
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   // Completion is a single-cycle pulse
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

@@ design/hqe_datapath.sv @@
`default_nettype none

module hqe_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hqe_pkg::req_type                  req_data,
   input  wire logic                              csr_write,
   input  wire logic [hqe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hqe_pkg::DATA_W-1:0]        csr_data,
   input  wire hqe_pkg::dp_cmd_type               cmd,
   output hqe_pkg::dp_sts_type                    sts,
   output hqe_pkg::rsp_type                       rsp_data
);

   localparam int CW = hqe_pkg::COUNT_WIDTH;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
      return (&c) ? c : c + CW'(1);
   endfunction

   // Configuration
   logic signed [hqe_pkg::DATA_W-1:0] low_ff, high_ff;

   // Item and working registers
   hqe_pkg::req_type                  item_ff;
   logic [CW-1:0]                     under_ff, over_ff, total_ff;
   logic [hqe_pkg::BIN_CNT_W-1:0]     b_ff, b_in;
   logic [hqe_pkg::USED_W-1:0]        used_ff;
   logic [hqe_pkg::PROD_W-1:0]        prod_ff;
   logic                              neg_ff;
   logic [hqe_pkg::DIV_D_W-1:0]       qm_ff;
   logic signed [hqe_pkg::DATA_W-1:0] qval_ff;
   logic [1:0]                        res_status_ff;
   hqe_pkg::rsp_type                  rsp_ff;

   // Bin store
   logic [CW-1:0]                     mem [hqe_pkg::NUM_BINS];
   logic [hqe_pkg::NUM_BINS-1:0]      bin_vld_ff;
   logic [CW-1:0]                     rd_data_ff;
   logic                              rd_vld_ff;
   logic [hqe_pkg::BIN_CNT_W-1:0]     rd_addr;
   logic                              rd_in_range;
   logic [CW-1:0]                     bin_val;

   // Arithmetic
   logic signed [16:0]                span, off;
   logic [hqe_pkg::FRAC_W-1:0]        frac_sat;
   logic [CW:0]                       limit;
   logic signed [hqe_pkg::QP_W-1:0]   qprod;
   logic [hqe_pkg::QP_W-1:0]          qmag;
   logic [hqe_pkg::QR_P_W-1:0]        qrec;
   logic [hqe_pkg::DIV_Q_W-1:0]       qquo;
   logic [hqe_pkg::DIV_D_W-1:0]       div_dividend;
   logic [hqe_pkg::DIV_V_W-1:0]       div_divisor;
   logic                              div_done;
   logic [hqe_pkg::DIV_Q_W-1:0]       div_q;
   logic signed [17:0]                fdiv, qsum;
   logic [hqe_pkg::BIN_CNT_W+5:0]     bin_ext;
   logic [hqe_pkg::TOT_EXT_W-1:0]     tot_ext;
   logic [31:0]                       tot32;

   assign span = {high_ff[15], high_ff} - {low_ff[15], low_ff};
   assign off  = {item_ff.sample[15], item_ff.sample} - {low_ff[15], low_ff};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= hqe_pkg::RANGE_LOW_RST;
         high_ff <= hqe_pkg::RANGE_HIGH_RST;
      end else if (csr_write) begin
         case (csr_index)
            hqe_pkg::CSR_RANGE_LOW:  low_ff  <= csr_data;
            hqe_pkg::CSR_RANGE_HIGH: high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Counters
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         under_ff <= '0;
         over_ff  <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.inc_total) total_ff <= sat_inc(total_ff);
         if (cmd.inc_under) under_ff <= sat_inc(under_ff);
         if (cmd.inc_over)  over_ff  <= sat_inc(over_ff);
      end
   end

   // Quantile limit: floor(total * q)
   assign frac_sat = (item_ff.fraction > hqe_pkg::FRAC_ONE) ? hqe_pkg::FRAC_ONE
                                                            : item_ff.fraction;
   assign limit    = prod_ff[hqe_pkg::PROD_W-1:16];

   // Bin read port
   assign rd_addr     = cmd.rd_next ? b_ff + hqe_pkg::BIN_CNT_W'(1) : b_ff;
   assign rd_in_range = (rd_addr < hqe_pkg::BIN_CNT_W'(hqe_pkg::NUM_BINS));
   assign bin_val     = rd_vld_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_addr[hqe_pkg::BIN_IDX_W-1:0]];
         rd_vld_ff  <= rd_in_range && bin_vld_ff[rd_addr[hqe_pkg::BIN_IDX_W-1:0]];
      end
      if (cmd.bin_write) begin
         mem[b_ff[hqe_pkg::BIN_IDX_W-1:0]] <= sat_inc(bin_val);
      end
   end

   // Entry valid bits; an unwritten bin reads as zero
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         bin_vld_ff <= '0;
      end else if (cmd.bin_write) begin
         bin_vld_ff[b_ff[hqe_pkg::BIN_IDX_W-1:0]] <= 1'b1;
      end
   end

   // Divider operands: NUM_BINS * offset over the span
   assign div_dividend = hqe_pkg::DIV_D_W'(hqe_pkg::NUM_BINS)
                       * hqe_pkg::DIV_D_W'(off[15:0]);
   assign div_divisor  = span[15:0];

   hqe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_bin),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Quantile position: b * span, magnitude biased so the quotient floors
   assign qprod = $signed({{(hqe_pkg::QP_W-hqe_pkg::BIN_CNT_W){1'b0}}, b_ff})
                * $signed({{(hqe_pkg::QP_W-17){span[16]}}, span});
   assign qmag  = qprod[hqe_pkg::QP_W-1] ? hqe_pkg::QP_W'(-qprod) : hqe_pkg::QP_W'(qprod);

   // Divide by NUM_BINS through a reciprocal multiply
   assign qrec = hqe_pkg::QR_P_W'(qm_ff) * hqe_pkg::QR_P_W'(hqe_pkg::QR_MUL);
   assign qquo = qrec[hqe_pkg::QR_SH+hqe_pkg::DIV_Q_W-1:hqe_pkg::QR_SH];

   // Floor toward minus infinity for a negative product
   assign fdiv = neg_ff ? -$signed({1'b0, qquo}) : $signed({1'b0, qquo});
   assign qsum = $signed({{2{low_ff[15]}}, low_ff}) + fdiv;

   // Bin / step index
   always_comb begin
      b_in = b_ff;
      if (cmd.accept || cmd.prod_load) begin
         b_in = '0;
      end else if (cmd.bin_capture) begin
         b_in = (div_q > hqe_pkg::DIV_Q_W'(hqe_pkg::NUM_BINS - 1))
              ? hqe_pkg::BIN_CNT_W'(hqe_pkg::NUM_BINS - 1)
              : div_q[hqe_pkg::BIN_CNT_W-1:0];
      end else if (cmd.walk_step) begin
         b_in = b_ff + hqe_pkg::BIN_CNT_W'(1);
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      b_ff <= b_in;
      if (cmd.accept) begin
         item_ff <= req_data;
         qval_ff <= '0;
      end
      if (cmd.prod_load) begin
         prod_ff <= hqe_pkg::PROD_W'(total_ff) * hqe_pkg::PROD_W'(frac_sat);
         used_ff <= hqe_pkg::USED_W'(under_ff);
      end else if (cmd.walk_step) begin
         used_ff <= used_ff + hqe_pkg::USED_W'(bin_val);
      end
      if (cmd.div_query) begin
         neg_ff <= qprod[hqe_pkg::QP_W-1];
         qm_ff  <= qmag[hqe_pkg::DIV_D_W-1:0]
                 + (qprod[hqe_pkg::QP_W-1] ? hqe_pkg::DIV_D_W'(hqe_pkg::NUM_BINS - 1)
                                           : '0);
      end
      if (cmd.q_capture) begin
         qval_ff <= qsum[15:0];
      end
      if (cmd.status_load) begin
         res_status_ff <= cmd.status_code;
      end
   end

   // Result register
   assign bin_ext = {6'b0, b_ff};
   assign tot_ext = {32'b0, total_ff};
   assign tot32   = (tot_ext > hqe_pkg::TOT_EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : tot_ext[31:0];

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status         <= res_status_ff;
         rsp_ff.bin_index      <= bin_ext[5:0];
         rsp_ff.quantile_value <= qval_ff;
         rsp_ff.sample_total   <= tot32;
      end
   end

   assign rsp_data = rsp_ff;

   // Status to the controller
   assign sts.opcode    = item_ff.opcode;
   assign sts.below     = (item_ff.sample < low_ff);
   assign sts.above     = (item_ff.sample >= high_ff);
   assign sts.walk_stop = (b_ff == hqe_pkg::BIN_CNT_W'(hqe_pkg::NUM_BINS))
                       || (used_ff > hqe_pkg::USED_W'(limit));
   assign sts.div_done  = div_done;

   // A binned sample always lands inside the store
   assert property (@(posedge clock) disable iff (reset)
      cmd.bin_write |-> (b_ff < hqe_pkg::BIN_CNT_W'(hqe_pkg::NUM_BINS)))
      else $error("bin write beyond the last bin");

   // The walk never steps past the last bin
   assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (b_ff < hqe_pkg::BIN_CNT_W'(hqe_pkg::NUM_BINS)))
      else $error("quantile walk stepped past the last bin");

endmodule

`default_nettype wire

@@ design/hqe_ctrl.sv @@
`default_nettype none

module hqe_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire hqe_pkg::dp_sts_type  sts,
   output hqe_pkg::dp_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIV_BIN,
      S_BIN_RD,
      S_BIN_WR,
      S_Q_LIM,
      S_WALK,
      S_Q_DIV,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.opcode)
               hqe_pkg::OP_ADD: begin
                  if (sts.below) begin
                     cmd.inc_total   = 1'b1;
                     cmd.inc_under   = 1'b1;
                     cmd.status_load = 1'b1;
                     cmd.status_code = hqe_pkg::ST_BELOW;
                     state_in        = S_RESP;
                  end else if (sts.above) begin
                     cmd.inc_total   = 1'b1;
                     cmd.inc_over    = 1'b1;
                     cmd.status_load = 1'b1;
                     cmd.status_code = hqe_pkg::ST_ABOVE;
                     state_in        = S_RESP;
                  end else begin
                     cmd.div_bin = 1'b1;
                     state_in    = S_DIV_BIN;
                  end
               end
               hqe_pkg::OP_QUERY: begin
                  cmd.prod_load   = 1'b1;
                  cmd.status_load = 1'b1;
                  cmd.status_code = hqe_pkg::ST_DONE;
                  state_in        = S_Q_LIM;
               end
               hqe_pkg::OP_CLEAR: begin
                  cmd.clear_all   = 1'b1;
                  cmd.status_load = 1'b1;
                  cmd.status_code = hqe_pkg::ST_DONE;
                  state_in        = S_RESP;
               end
               default: begin
                  cmd.status_load = 1'b1;
                  cmd.status_code = hqe_pkg::ST_DONE;
                  state_in        = S_RESP;
               end
            endcase
         end
         S_DIV_BIN: begin
            if (sts.div_done) begin
               cmd.bin_capture = 1'b1;
               state_in        = S_BIN_RD;
            end
         end
         S_BIN_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_BIN_WR;
         end
         S_BIN_WR: begin
            cmd.bin_write   = 1'b1;
            cmd.inc_total   = 1'b1;
            cmd.status_load = 1'b1;
            cmd.status_code = hqe_pkg::ST_BINNED;
            state_in        = S_RESP;
         end
         S_Q_LIM: begin
            // fetch bin 0 for the first walk step
            cmd.mem_rd = 1'b1;
            state_in   = S_WALK;
         end
         S_WALK: begin
            if (sts.walk_stop) begin
               cmd.div_query = 1'b1;
               state_in      = S_Q_DIV;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.mem_rd    = 1'b1;
               cmd.rd_next   = 1'b1;
            end
         end
         S_Q_DIV: begin
            // position from the registered magnitude
            cmd.q_capture = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new result only appears out of the response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result raised outside the response state");

endmodule

`default_nettype wire
